FILE: hw/rtl/tlfl_pkg.sv
// ----------------------------------------------------------------------------
// Temporal logic formula lexer: shared types and helpers
// Token kinds, the token record, the push bundle between the lexer core and
// the result queue, and the character class and keyword functions.
// ----------------------------------------------------------------------------
package tlfl_pkg;

  // Width constants of the token fields.
  localparam int unsigned KindW  = 5;
  localparam int unsigned PosW   = 16;
  localparam int unsigned LenW   = 16;
  localparam int unsigned CharW  = 8;
  localparam int unsigned KwW    = 40;  // first five characters of a word
  localparam int unsigned WcW    = 3;   // word character count, 0..6
  localparam int unsigned MaxRes = 3;   // results one character can cause
  localparam int unsigned ResCntW = 2;

  // Depth of the result queue.
  localparam int unsigned FifoDepth = 8;

  // Token kinds.
  typedef enum logic [KindW-1:0] {
    KIND_ATOM   = 5'd0,
    KIND_NUMBER = 5'd1,
    KIND_TRUE   = 5'd2,
    KIND_FALSE  = 5'd3,
    KIND_EF     = 5'd4,
    KIND_AF     = 5'd5,
    KIND_EG     = 5'd6,
    KIND_AG     = 5'd7,
    KIND_EU     = 5'd8,
    KIND_AU     = 5'd9,
    KIND_EW     = 5'd10,
    KIND_AW     = 5'd11,
    KIND_EX     = 5'd12,
    KIND_AX     = 5'd13,
    KIND_LPAREN = 5'd14,
    KIND_RPAREN = 5'd15,
    KIND_LBRACK = 5'd16,
    KIND_RBRACK = 5'd17,
    KIND_COMMA  = 5'd18,
    KIND_ARROW  = 5'd19,
    KIND_EQ     = 5'd20,
    KIND_NE     = 5'd21,
    KIND_LE     = 5'd22,
    KIND_GE     = 5'd23,
    KIND_LT     = 5'd24,
    KIND_GT     = 5'd25,
    KIND_NOT    = 5'd26,
    KIND_AND    = 5'd27,
    KIND_OR     = 5'd28,
    KIND_END    = 5'd29,
    KIND_ERROR  = 5'd30
  } kind_e;

  // One result token.
  typedef struct packed {
    logic              last_of_run;
    logic [LenW-1:0]   length;
    logic [PosW-1:0]   start_pos;
    kind_e             kind;
  } tok_t;

  // Results of one accepted character, handed from the core to the queue.
  typedef struct packed {
    logic [ResCntW-1:0]  count;
    tok_t [MaxRes-1:0]   tok;
  } push_t;

  // Keyword spellings, first character in the lowest byte.
  localparam logic [KwW-1:0] KwTrue  = 40'h00_65_75_72_74;
  localparam logic [KwW-1:0] KwFalse = 40'h65_73_6c_61_66;

  // Character classes.
  function automatic logic is_alpha(input logic [CharW-1:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [CharW-1:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_ident(input logic [CharW-1:0] c);
    return is_alpha(c) || is_digit(c) || c == 8'h5f || c == 8'h2e || c == 8'h2d;
  endfunction

  // Kind of a finished word from its stored characters and length.
  function automatic kind_e word_kind(input logic [KwW-1:0] kw, input logic [WcW-1:0] wc);
    kind_e k;
    k = KIND_ATOM;
    if (wc == 3'd4 && kw == KwTrue) begin
      k = KIND_TRUE;
    end else if (wc == 3'd5 && kw == KwFalse) begin
      k = KIND_FALSE;
    end else if (wc == 3'd1 && kw == 40'h45) begin
      k = KIND_EU;
    end else if (wc == 3'd1 && kw == 40'h41) begin
      k = KIND_AU;
    end else if (wc == 3'd2 && kw[39:16] == 24'h0 && (kw[7:0] == 8'h45 || kw[7:0] == 8'h41)) begin
      unique case (kw[15:8])
        8'h46:   k = (kw[7:0] == 8'h45) ? KIND_EF : KIND_AF;
        8'h47:   k = (kw[7:0] == 8'h45) ? KIND_EG : KIND_AG;
        8'h55:   k = (kw[7:0] == 8'h45) ? KIND_EU : KIND_AU;
        8'h57:   k = (kw[7:0] == 8'h45) ? KIND_EW : KIND_AW;
        8'h58:   k = (kw[7:0] == 8'h45) ? KIND_EX : KIND_AX;
        default: k = KIND_ATOM;
      endcase
    end
    return k;
  endfunction

  // Kind of a comparison or negation, one or two characters long.
  function automatic kind_e op_kind(input logic [CharW-1:0] pc, input logic two);
    kind_e k;
    unique case (pc)
      8'h3d:   k = KIND_EQ;
      8'h21:   k = two ? KIND_NE : KIND_NOT;
      8'h3c:   k = two ? KIND_LE : KIND_LT;
      default: k = two ? KIND_GE : KIND_GT;
    endcase
    return k;
  endfunction

  // Builds a token record.
  function automatic tok_t mk_tok(input kind_e k, input logic [PosW-1:0] s,
                                  input logic [LenW-1:0] l);
    tok_t t;
    t.kind        = k;
    t.start_pos   = s;
    t.length      = l;
    t.last_of_run = 1'b0;
    return t;
  endfunction

endpackage

FILE: hw/rtl/tlfl_lex_core.sv
// ----------------------------------------------------------------------------
// Lexer core
// Holds the lexer state and turns one accepted character into up to three
// tokens in a single pass of combinational logic.
// ----------------------------------------------------------------------------
module tlfl_lex_core import tlfl_pkg::*; #(
  parameter logic [PosW-1:0] PosCap = 16'hFFFF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [CharW-1:0] ch_i,
  input  logic             last_i,
  output push_t            push_o
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_PEND
  } mode_e;

  mode_e            mode_q, mode_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  start_q, start_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [KwW-1:0]   kw_q, kw_d;
  logic [WcW-1:0]   wc_q, wc_d;
  logic [CharW-1:0] pend_q, pend_d;
  logic             err_q, err_d;

  // Next state and the tokens of this character.
  always_comb begin
    logic               grow;
    logic               consumed;
    logic [ResCntW-1:0] n;
    tok_t [MaxRes-1:0]  res;

    mode_d   = mode_q;
    pos_d    = pos_q;
    start_d  = start_q;
    len_d    = len_q;
    kw_d     = kw_q;
    wc_d     = wc_q;
    pend_d   = pend_q;
    err_d    = err_q;
    grow     = 1'b0;
    consumed = 1'b0;
    n        = '0;
    res      = '0;

    if (!err_q) begin
      // Continue or close the token in progress.
      unique case (mode_q)
        MODE_IDENT: begin
          grow = is_ident(ch_i);
        end
        MODE_NUMBER: begin
          grow = is_digit(ch_i) || ch_i == 8'h2e;
        end
        MODE_PEND: begin
          if (pend_q == 8'h2d) begin
            if (ch_i == 8'h3e) begin
              res[n]   = mk_tok(KIND_ARROW, start_q, 16'd2);
              n        = n + 2'd1;
              mode_d   = MODE_IDLE;
              consumed = 1'b1;
            end else if (is_ident(ch_i)) begin
              mode_d = MODE_IDENT;
              grow   = 1'b1;
            end
          end else if (ch_i == 8'h3d) begin
            res[n]   = mk_tok(op_kind(pend_q, 1'b1), start_q, 16'd2);
            n        = n + 2'd1;
            mode_d   = MODE_IDLE;
            consumed = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (grow) begin
        consumed = 1'b1;
        if (len_q != 16'hFFFF) begin
          len_d = len_q + 16'd1;
        end
        if (wc_q < 3'd5) begin
          for (int i = 0; i < 5; i++) begin
            if (wc_q == WcW'(i)) begin
              kw_d[i*8 +: 8] = ch_i;
            end
          end
          wc_d = wc_q + 3'd1;
        end else if (wc_q == 3'd5) begin
          wc_d = 3'd6;
        end
      end else if (!consumed && mode_q != MODE_IDLE) begin
        // The character ends the pending token.
        unique case (mode_q)
          MODE_IDENT:  res[n] = mk_tok(word_kind(kw_q, wc_q), start_q, len_q);
          MODE_NUMBER: res[n] = mk_tok(KIND_NUMBER, start_q, len_q);
          default: begin
            res[n] = mk_tok((pend_q == 8'h2d) ? KIND_ATOM : op_kind(pend_q, 1'b0),
                            start_q, len_q);
          end
        endcase
        n      = n + 2'd1;
        mode_d = MODE_IDLE;
      end

      // A character not taken by the old token starts a new one.
      if (!consumed && !is_space(ch_i)) begin
        if (is_alpha(ch_i) || ch_i == 8'h5f || ch_i == 8'h2e || is_digit(ch_i) ||
            ch_i == 8'h2d || ch_i == 8'h3d || ch_i == 8'h21 || ch_i == 8'h3c ||
            ch_i == 8'h3e) begin
          start_d = pos_q;
          len_d   = 16'd1;
          kw_d    = {32'h0, ch_i};
          wc_d    = 3'd1;
          if (is_digit(ch_i)) begin
            mode_d = MODE_NUMBER;
          end else if (is_alpha(ch_i) || ch_i == 8'h5f || ch_i == 8'h2e) begin
            mode_d = MODE_IDENT;
          end else begin
            mode_d = MODE_PEND;
            pend_d = ch_i;
          end
        end else begin
          unique case (ch_i)
            8'h28:   res[n] = mk_tok(KIND_LPAREN, pos_q, 16'd1);
            8'h29:   res[n] = mk_tok(KIND_RPAREN, pos_q, 16'd1);
            8'h5b:   res[n] = mk_tok(KIND_LBRACK, pos_q, 16'd1);
            8'h5d:   res[n] = mk_tok(KIND_RBRACK, pos_q, 16'd1);
            8'h2c:   res[n] = mk_tok(KIND_COMMA, pos_q, 16'd1);
            8'h26:   res[n] = mk_tok(KIND_AND, pos_q, 16'd1);
            8'h7c:   res[n] = mk_tok(KIND_OR, pos_q, 16'd1);
            default: begin
              res[n] = mk_tok(KIND_ERROR, pos_q, 16'd1);
              err_d  = 1'b1;
            end
          endcase
          n = n + 2'd1;
        end
      end

      if (pos_q < PosCap) begin
        pos_d = pos_q + 16'd1;
      end

      // Unless an error was seen, the last character flushes the open token and closes the formula.
      if (last_i && !err_d) begin
        if (mode_d != MODE_IDLE) begin
          unique case (mode_d)
            MODE_IDENT:  res[n] = mk_tok(word_kind(kw_d, wc_d), start_d, len_d);
            MODE_NUMBER: res[n] = mk_tok(KIND_NUMBER, start_d, len_d);
            default: begin
              res[n] = mk_tok((pend_d == 8'h2d) ? KIND_ATOM : op_kind(pend_d, 1'b0),
                              start_d, len_d);
            end
          endcase
          n = n + 2'd1;
        end
        res[n] = mk_tok(KIND_END, pos_d, 16'd0);
        n      = n + 2'd1;
      end
    end

    // Back to the reset state after the last character.
    if (last_i) begin
      mode_d  = MODE_IDLE;
      pos_d   = '0;
      start_d = '0;
      len_d   = '0;
      kw_d    = '0;
      wc_d    = '0;
      pend_d  = '0;
      err_d   = 1'b0;
    end

    if (n != 2'd0) begin
      res[n - 2'd1].last_of_run = 1'b1;
    end

    push_o.count = take_i ? n : '0;
    push_o.tok   = res;
  end

  // State registers, updated on each accepted character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      kw_q    <= '0;
      wc_q    <= '0;
      pend_q  <= '0;
      err_q   <= 1'b0;
    end else if (take_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      kw_q    <= kw_d;
      wc_q    <= wc_d;
      pend_q  <= pend_d;
      err_q   <= err_d;
    end
  end

endmodule

FILE: hw/rtl/tlfl_out_fifo.sv
// ----------------------------------------------------------------------------
// Result queue
// Takes up to three tokens per cycle from the lexer core and hands them out
// one transaction at a time.
// ----------------------------------------------------------------------------
module tlfl_out_fifo import tlfl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  valid_o,
  input  logic  ready_i,
  output tok_t  tok_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  tok_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  // Space for a full burst of results is checked against the stored count.
  assign room_o  = cnt_q <= CntW'(FifoDepth - MaxRes);
  assign valid_o = cnt_q != '0;
  assign tok_o   = mem_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;

  // Pointer and fill count.
  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.count);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Token storage, written in consecutive slots.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (ResCntW'(i) < push_i.count) begin
        mem_q[wr_ptr_q + PtrW'(i)] <= push_i.tok[i];
      end
    end
  end

endmodule

FILE: hw/rtl/temporal_logic_formula_lexer_unit.sv
// ----------------------------------------------------------------------------
// Temporal logic formula lexer
// Splits a character stream into formula tokens (kind, start, length).
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  s_*     | in        | tdata[7:0] character, tlast ends the formula
//  m_*     | out       | tdata kind/start_pos/length, tlast last token of a char
//
// One character is taken per cycle while the queue has room; its tokens (at most three)
// are written to an eight-entry result queue in the same cycle and show on m_* from the next.
// Input is taken whenever the queue has room for three tokens, so a stalled
// output side holds s_tready_o low once six or more tokens wait.
// Reset is asynchronous and active low; it empties the queue and restarts
// the lexer at position zero.
// ----------------------------------------------------------------------------
module temporal_logic_formula_lexer_unit import tlfl_pkg::*; #(
  parameter longint unsigned MAX_FORMULA_LEN = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] ch
  input  logic        s_tlast_i,   // last
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o,   // [4:0] kind, [20:5] start_pos, [36:21] length
  output logic        m_tlast_o    // last_of_run
);

  localparam logic [PosW-1:0] PosCap =
    (MAX_FORMULA_LEN < 64'd65535) ? PosW'(MAX_FORMULA_LEN) : 16'hFFFF;

  push_t push;
  tok_t  tok;
  logic  take;

  assign take = s_tvalid_i && s_tready_o;

  tlfl_lex_core #(
    .PosCap (PosCap)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .ch_i   (s_tdata_i),
    .last_i (s_tlast_i),
    .push_o (push)
  );

  tlfl_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (s_tready_o),
    .valid_o (m_tvalid_o),
    .ready_i (m_tready_i),
    .tok_o   (tok)
  );

  // Output packing.
  assign m_tdata_o = {3'b000, tok.length, tok.start_pos, tok.kind};
  assign m_tlast_o = tok.last_of_run;

endmodule

FILE: hw/rtl/tlfl_checker.sv
// ----------------------------------------------------------------------------
// Lexer port checker
// Watches the top level's ports for token and handshake rules.
// ----------------------------------------------------------------------------
module tlfl_checker import tlfl_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid_i,
  input logic        s_tready_o,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [39:0] m_tdata_o,
  input logic        m_tlast_o
);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> $stable(m_tdata_o) && $stable(m_tlast_o))
    else $error("result changed while stalled");

  // The end token has no length and closes its character's results.
  a_end_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[4:0] == KIND_END |-> m_tlast_o && m_tdata_o[36:21] == 16'd0)
    else $error("malformed end token");

  // An error token is one character long and ends its character's results.
  a_err_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[4:0] == KIND_ERROR |-> m_tlast_o && m_tdata_o[36:21] == 16'd1)
    else $error("malformed error token");

  // No result appears without a character taken before it.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid_o && !(s_tvalid_i && s_tready_o) |=> !m_tvalid_o)
    else $error("result from nowhere");

endmodule

bind temporal_logic_formula_lexer_unit tlfl_checker u_tlfl_checker (.*);
